// File: rtl/core/bqtdf2_pkg.sv
// Package for the multichannel TDF-II biquad: widths, register indexes,
// microcode control word and ROM, and saturating arithmetic helpers.
// No dependencies.
package bqtdf2_pkg;

   localparam int CHANNELS   = 2;
   localparam int CHAN_W     = 1;
   localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 32;
   localparam int COEF_FRAC  = 28;
   localparam int STATE_W    = 56;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int Q_W        = STATE_W + 1 - COEF_FRAC;

   localparam int NUM_REGS   = 5;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);

   localparam int NUM_STEPS  = 8;
   localparam int STEP_W     = $clog2(NUM_STEPS);

   localparam logic signed [STATE_W:0] ROUND_HALF = (STATE_W + 1)'(1) << (COEF_FRAC - 1);
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

   typedef enum logic [REG_IDX_W-1:0] {
      REG_B0,
      REG_B1,
      REG_B2,
      REG_A1,
      REG_A2
   } reg_idx_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_IN,
      SEQ_WAIT_OUT
   } seq_op_type;

   typedef enum logic {
      MA_X,
      MA_Y
   } mul_a_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_ADD_D1,
      ACC_LOAD_PROD,
      ACC_SUB_PROD
   } acc_op_type;

   typedef enum logic [1:0] {
      AUX_HOLD,
      AUX_LOAD_PROD,
      AUX_SUB_PROD,
      AUX_ADD_D2
   } aux_op_type;

   typedef struct packed {
      seq_op_type  seq_op;
      logic [STEP_W-1:0] jump;
      mul_a_type   mul_a;
      reg_idx_type coef;
      acc_op_type  acc_op;
      aux_op_type  aux_op;
      logic        y_load;
   } ctrl_type;

   localparam logic [STEP_W-1:0] STEP_IDLE    = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_MUL_B0  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_ACC_D1  = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_ROUND   = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_MUL_A1  = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_MUL_A2  = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_MERGE   = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_DONE    = STEP_W'(7);

   function automatic ctrl_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = '{seq_op: SEQ_NEXT, jump: STEP_IDLE, mul_a: MA_X, coef: REG_B0,
            acc_op: ACC_HOLD, aux_op: AUX_HOLD, y_load: 1'b0};
      case (step)
         STEP_IDLE: begin
            w.seq_op = SEQ_WAIT_IN;
            w.jump   = STEP_MUL_B0;
         end
         STEP_MUL_B0: begin
            w.coef = REG_B0;
         end
         STEP_ACC_D1: begin
            w.coef   = REG_B1;
            w.acc_op = ACC_ADD_D1;
         end
         STEP_ROUND: begin
            w.coef   = REG_B2;
            w.y_load = 1'b1;
            w.aux_op = AUX_LOAD_PROD;
         end
         STEP_MUL_A1: begin
            w.mul_a  = MA_Y;
            w.coef   = REG_A1;
            w.acc_op = ACC_LOAD_PROD;
         end
         STEP_MUL_A2: begin
            w.mul_a  = MA_Y;
            w.coef   = REG_A2;
            w.aux_op = AUX_SUB_PROD;
         end
         STEP_MERGE: begin
            w.acc_op = ACC_SUB_PROD;
            w.aux_op = AUX_ADD_D2;
         end
         STEP_DONE: begin
            w.seq_op = SEQ_WAIT_OUT;
            w.jump   = STEP_IDLE;
         end
         default: begin
            w.seq_op = SEQ_WAIT_OUT;
            w.jump   = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [STATE_W:0] s);
      logic signed [STATE_W-1:0] r;
      if (s[STATE_W] != s[STATE_W-1]) begin
         r = s[STATE_W] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
      end else begin
         r = s[STATE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [STATE_W-1:0] add_sat(input logic signed [STATE_W-1:0] a,
                                                         input logic signed [STATE_W-1:0] b);
      logic signed [STATE_W:0] s;
      s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
      return sat_state(s);
   endfunction

   function automatic logic signed [STATE_W-1:0] sub_sat(input logic signed [STATE_W-1:0] a,
                                                         input logic signed [STATE_W-1:0] b);
      logic signed [STATE_W:0] s;
      s = {a[STATE_W-1], a} - {b[STATE_W-1], b};
      return sat_state(s);
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
      logic signed [STATE_W-1:0] r;
      if ((p[PROD_W-1:STATE_W-1] == '0) || (p[PROD_W-1:STATE_W-1] == '1)) begin
         r = p[STATE_W-1:0];
      end else begin
         r = p[PROD_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
      end
      return r;
   endfunction

   // round half up at the sample LSB, then clamp to the sample range
   function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [STATE_W-1:0] a);
      logic signed [STATE_W:0] r;
      logic signed [Q_W-1:0]   q;
      logic signed [SAMPLE_W-1:0] y;
      r = {a[STATE_W-1], a} + ROUND_HALF;
      q = r[STATE_W:COEF_FRAC];
      if (q > Q_MAX) begin
         y = SAMPLE_W'(Q_MAX);
      end else if (q < Q_MIN) begin
         y = SAMPLE_W'(Q_MIN);
      end else begin
         y = q[SAMPLE_W-1:0];
      end
      return y;
   endfunction

endpackage

// File: rtl/core/biquad_tdf2_multichannel_top.sv
// Multichannel TDF-II biquad: microcoded sequencer over one shared multiplier.
// Depends on bqtdf2_pkg.
// Items are taken one at a time: a new one is accepted only after the 8-step
// microprogram has run all five products through the single 24x32 multiplier.
// A result waiting on rsp_stall holds the last step until the output frees.
// Reset (synchronous): coefficients and all channel state words cleared.
module biquad_tdf2_multichannel_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [bqtdf2_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic        [bqtdf2_pkg::CHAN_W-1:0]   req_chan,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [bqtdf2_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic        [bqtdf2_pkg::CHAN_W-1:0]   rsp_out_chan,
   input  logic                                   csr_wen,
   input  logic        [bqtdf2_pkg::REG_IDX_W-1:0] csr_index,
   input  logic        [bqtdf2_pkg::COEF_W-1:0]   csr_wdata
);
   import bqtdf2_pkg::*;

   logic [STEP_W-1:0]          step_ff, step_in;
   ctrl_type                   uc;

   logic signed [COEF_W-1:0]   coef_ff [NUM_REGS];
   logic signed [STATE_W-1:0]  d1_ff [CHANNELS];
   logic signed [STATE_W-1:0]  d2_ff [CHANNELS];

   logic signed [SAMPLE_W-1:0] x_ff;
   logic [CHAN_W-1:0]          chan_ff;
   logic [CHAN_IDX_W-1:0]      cidx_ff, cidx_in;
   logic signed [STATE_W-1:0]  prod_ff, prod_in;
   logic signed [STATE_W-1:0]  acc_ff, acc_in;
   logic signed [STATE_W-1:0]  aux_ff, aux_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic [CHAN_W-1:0]          rsp_chan_ff;

   logic signed [SAMPLE_W-1:0] mul_a;
   logic signed [COEF_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]   prod_full;
   logic signed [STATE_W-1:0]  d1_rd, d2_rd;
   logic                       req_accept, out_free, finish;

   assign uc = ucode_rom(step_ff);

   assign req_stall  = (uc.seq_op != SEQ_WAIT_IN);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (uc.seq_op == SEQ_WAIT_OUT) && out_free;

   assign cidx_in = (int'(req_chan) >= CHANNELS) ? CHAN_IDX_W'(CHANNELS - 1)
                                                  : CHAN_IDX_W'(req_chan);

   assign mul_a     = (uc.mul_a == MA_Y) ? y_ff : x_ff;
   assign mul_b     = coef_ff[uc.coef];
   assign prod_full = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_in   = sat_prod(prod_full);

   assign d1_rd = d1_ff[cidx_ff];
   assign d2_rd = d2_ff[cidx_ff];

   always_comb begin
      step_in = step_ff;
      case (uc.seq_op)
         SEQ_WAIT_IN:  step_in = req_valid ? uc.jump : step_ff;
         SEQ_NEXT:     step_in = step_ff + STEP_W'(1);
         SEQ_WAIT_OUT: step_in = out_free ? uc.jump : step_ff;
         default:      step_in = STEP_IDLE;
      endcase
   end

   always_comb begin
      case (uc.acc_op)
         ACC_ADD_D1:    acc_in = add_sat(prod_ff, d1_rd);
         ACC_LOAD_PROD: acc_in = prod_ff;
         ACC_SUB_PROD:  acc_in = sub_sat(acc_ff, prod_ff);
         default:       acc_in = acc_ff;
      endcase
      case (uc.aux_op)
         AUX_LOAD_PROD: aux_in = prod_ff;
         AUX_SUB_PROD:  aux_in = sub_sat(aux_ff, prod_ff);
         AUX_ADD_D2:    aux_in = add_sat(aux_ff, d2_rd);
         default:       aux_in = aux_ff;
      endcase
      y_in = uc.y_load ? round_sat(acc_ff) : y_ff;
      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_wen && (csr_index <= REG_A2)) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            d1_ff[i] <= '0;
            d2_ff[i] <= '0;
         end
      end else if (finish) begin
         d1_ff[cidx_ff] <= aux_ff;
         d2_ff[cidx_ff] <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff    <= req_sample_in;
         chan_ff <= req_chan;
         cidx_ff <= cidx_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      aux_ff  <= aux_in;
      y_ff    <= y_in;
      if (finish) begin
         rsp_sample_ff <= y_ff;
         rsp_chan_ff   <= chan_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_out_chan   = rsp_chan_ff;

endmodule

// File: rtl/core/bqtdf2_check.sv
// Port-level checker for the multichannel TDF-II biquad, bound to the top level.
// Depends on bqtdf2_pkg and biquad_tdf2_multichannel_top.
module bqtdf2_check (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [bqtdf2_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input logic        [bqtdf2_pkg::CHAN_W-1:0]   rsp_out_chan
);
   import bqtdf2_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out) && $stable(rsp_out_chan))
      else $error("stalled result changed");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // a fresh result must trace back to an accepted item
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, NUM_STEPS))
      else $error("result without matching item");

endmodule

bind biquad_tdf2_multichannel_top bqtdf2_check u_bqtdf2_check (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for biquad_tdf2_multichannel_top: steps its own TDF-II biquad model per
// channel and checks every filtered sample. Needs bqtdf2_pkg and the top module.
module testbench;
   import bqtdf2_pkg::*;

   localparam longint STATE_HI    = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
   localparam longint STATE_LO    = -STATE_HI - 64'sd1;
   localparam longint SAMPLE_HI   = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
   localparam longint SAMPLE_LO   = -SAMPLE_HI - 64'sd1;
   localparam longint ROUND_BIAS  = 64'sd1 <<< (COEF_FRAC - 1);
   localparam int     CYCLE_LIMIT = 200000;
   localparam int     RAND_PHASE_ITEMS = 100;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic        [CHAN_W-1:0]   chan;
   } chan_sample_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [SAMPLE_W-1:0]   req_sample_in = '0;
   logic        [CHAN_W-1:0]     req_chan = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_sample_out;
   logic        [CHAN_W-1:0]     rsp_out_chan;
   logic                         csr_wen = 1'b0;
   logic        [REG_IDX_W-1:0]  csr_index = '0;
   logic        [COEF_W-1:0]     csr_wdata = '0;

   chan_sample_type              sample_feed_q[$];
   chan_sample_type              filtered_q[$];
   logic signed [COEF_W-1:0]     coef_q [NUM_REGS];
   logic signed [STATE_W-1:0]    delay_one [CHANNELS];
   logic signed [STATE_W-1:0]    delay_two [CHANNELS];
   int                           mismatch_count = 0;
   int                           burst_left = 0;
   int                           gap_left = 0;
   int                           rsp_seen = 0;
   int                           hold_left = 0;
   int                           stall_mode = 0;
   int                           mode_left = 0;

   biquad_tdf2_multichannel_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .req_chan       (req_chan),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_out_chan   (rsp_out_chan),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint clamp_state(input longint v);
      if (v > STATE_HI) return STATE_HI;
      if (v < STATE_LO) return STATE_LO;
      return v;
   endfunction

   task automatic biquad_predict(input logic signed [SAMPLE_W-1:0] x_in,
                                 input logic [CHAN_W-1:0] ch);
      longint          x, acc, y, s1, s2;
      int              c;
      chan_sample_type res;
      x = x_in;
      c = (ch >= CHANNELS) ? CHANNELS - 1 : ch;
      acc = clamp_state(clamp_state(x * coef_q[REG_B0]) + delay_one[c]);
      y = (acc + ROUND_BIAS) >>> COEF_FRAC;
      if (y > SAMPLE_HI) begin
         y = SAMPLE_HI;
      end else if (y < SAMPLE_LO) begin
         y = SAMPLE_LO;
      end
      s1 = clamp_state(clamp_state(x * coef_q[REG_B1]) - clamp_state(y * coef_q[REG_A1]));
      s1 = clamp_state(s1 + delay_two[c]);
      s2 = clamp_state(clamp_state(x * coef_q[REG_B2]) - clamp_state(y * coef_q[REG_A2]));
      delay_one[c] = s1[STATE_W-1:0];
      delay_two[c] = s2[STATE_W-1:0];
      res.sample = y[SAMPLE_W-1:0];
      res.chan   = ch;
      filtered_q.push_back(res);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 4))
         0: s = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_HI) : SAMPLE_W'(SAMPLE_LO);
         1: s = SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
         2: s = SAMPLE_W'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_within_two();
      return COEF_W'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
   endfunction

   task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] ch);
      chan_sample_type it;
      it.sample = s;
      it.chan   = ch;
      sample_feed_q.push_back(it);
   endtask

   task automatic write_coef(input reg_idx_type idx, input logic signed [COEF_W-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      coef_q[idx] = value;
   endtask

   task automatic load_coefs(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
      write_coef(REG_B0, b0);
      write_coef(REG_B1, b1);
      write_coef(REG_B2, b2);
      write_coef(REG_A1, a1);
      write_coef(REG_A2, a2);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // settle on the falling edge so every queue and valid update of the rising edge is seen
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (sample_feed_q.size() != 0 || filtered_q.size() != 0 || req_valid);
      @(posedge clock);
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++) begin
         push_item(random_sample(), CHAN_W'($urandom_range(0, 1)));
      end
   endtask

   always @(posedge clock) begin : req_side
      chan_sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            biquad_predict(req_sample_in, req_chan);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_feed_q.size() != 0) begin
               nxt = sample_feed_q.pop_front();
               req_valid     <= 1'b1;
               req_sample_in <= nxt.sample;
               req_chan      <= nxt.chan;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      chan_sample_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual sample %0d chan %0d",
                        $time, rsp_sample_out, rsp_out_chan);
               mismatch_count++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_sample_out !== want.sample) begin
                  $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                           $time, want.sample, rsp_sample_out);
                  mismatch_count++;
               end
               if (rsp_out_chan !== want.chan) begin
                  $display("%0t: out_chan mismatch: expected %0d, actual %0d",
                           $time, want.chan, rsp_out_chan);
                  mismatch_count++;
               end
            end
            rsp_seen++;
            // hold off long enough for the input side to back up
            if (rsp_seen == 60 || rsp_seen == 260) begin
               hold_left = 400;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= !rsp_stall;
            endcase
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      for (int r = 0; r < NUM_REGS; r++) begin
         coef_q[r] = '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         delay_one[c] = '0;
         delay_two[c] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // coefficients still at reset: output must stay zero
      push_item(SAMPLE_W'(SAMPLE_HI), 1'b0);
      push_item(SAMPLE_W'(SAMPLE_LO), 1'b1);
      push_item('0, 1'b0);
      push_item('1, 1'b1);
      wait_drained();

      // unity pass-through
      load_coefs(32'sh1000_0000, '0, '0, '0, '0);
      push_item(SAMPLE_W'(SAMPLE_HI), 1'b0);
      push_item(SAMPLE_W'(SAMPLE_LO), 1'b1);
      push_item(24'sh00_0001, 1'b0);
      push_item('1, 1'b1);
      push_item(24'h55_5555, 1'b0);
      push_item(24'hAA_AAAA, 1'b1);
      wait_drained();

      // half gain: exercise round half up on both signs
      load_coefs(32'sh0800_0000, '0, '0, '0, '0);
      push_item(24'sh00_0001, 1'b0);
      push_item('1, 1'b1);
      push_item(24'sh00_0003, 1'b0);
      push_item(-24'sh00_0003, 1'b1);
      push_item(24'sh00_0002, 1'b0);
      wait_drained();

      // extreme coefficients: drive output and state sums into saturation
      load_coefs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      repeat (3) push_item(SAMPLE_W'(SAMPLE_HI), 1'b0);
      repeat (3) push_item(SAMPLE_W'(SAMPLE_LO), 1'b1);
      push_item(24'sh00_0064, 1'b0);
      wait_drained();

      // low-pass
      load_coefs(32'sd18119393, 32'sd36238787, 32'sd18119393, -32'sd306821726, 32'sd110810156);
      push_random(RAND_PHASE_ITEMS);
      wait_drained();

      // high-pass: double zero at DC, complex pole pair
      load_coefs(32'sd241591910, -32'sd483183821, 32'sd241591910, -32'sd480499466,
                 32'sd217432719);
      push_random(RAND_PHASE_ITEMS);
      wait_drained();

      load_coefs(coef_within_two(), coef_within_two(), coef_within_two(), coef_within_two(),
                 coef_within_two());
      push_random(RAND_PHASE_ITEMS);
      wait_drained();

      load_coefs($urandom, $urandom, $urandom, 32'sh8000_0000, $urandom);
      push_random(RAND_PHASE_ITEMS);
      wait_drained();

      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/bqtdf2_pkg.sv
rtl/core/biquad_tdf2_multichannel_top.sv
rtl/core/bqtdf2_check.sv
sim/testbench.sv
